// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the engine top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// implication checked at every rising edge outside reset
`define GPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never hold outside reset
`define GPD_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GPD_ASSERT(label, clk, rst, prop, msg)
`define GPD_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/gpdma_pkg.sv =====
// ----------------------------------------------------------------------------
// gpdma_pkg
// types, codes and small decode functions of the eight-channel dma engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpdma_pkg;

  localparam int CHANNELS_DEF = 8;

  // command codes
  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_PREEMPT = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // channel register numbers
  localparam logic [3:0] REG_CTRL      = 4'd0;
  localparam logic [3:0] REG_BBASE     = 4'd1;
  localparam logic [3:0] REG_AOFF_LO   = 4'd2;
  localparam logic [3:0] REG_AOFF_HI   = 4'd3;
  localparam logic [3:0] REG_ABANK     = 4'd4;
  localparam logic [3:0] REG_COUNT_LO  = 4'd5;
  localparam logic [3:0] REG_COUNT_HI  = 4'd6;
  localparam logic [3:0] REG_IND_BANK  = 4'd7;
  localparam logic [3:0] REG_TABLE_LO  = 4'd8;
  localparam logic [3:0] REG_TABLE_HI  = 4'd9;
  localparam logic [3:0] REG_LINE      = 4'd10;
  localparam logic [3:0] REG_SPARE     = 4'd11;
  localparam logic [3:0] REG_SPARE_ALT = 4'd15;

  // a-address step modes
  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd2;

  localparam logic [4:0] TICK_COST  = 5'd8;
  localparam logic [4:0] ALIGN_BASE = 5'd16;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] reg_channel;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] pause_phase;
    logic [7:0] open_bus;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        byte_valid;
    logic [23:0] a_address;
    logic [7:0]  b_register;
    logic        to_a_bus;
    logic [2:0]  active_channel;
    logic        a_excluded;
    logic        port_refused;
    logic [4:0]  cycle_cost;
    logic        transfer_done;
    logic        busy_res;
  } out_item_t;

  // one channel's register set
  typedef struct packed {
    logic [7:0]  channel_control;
    logic [7:0]  b_base;
    logic [15:0] a_offset;
    logic [7:0]  a_bank;
    logic [15:0] byte_count;
    logic [7:0]  indirect_bank;
    logic [15:0] table_address;
    logic [7:0]  line_counter;
    logic [7:0]  spare_byte;
  } chan_regs_t;

  // register file write request
  typedef struct packed {
    logic        reg_en;
    logic [2:0]  reg_chan;
    logic [3:0]  reg_idx;
    logic [7:0]  reg_data;
    logic        step_en;
    logic [2:0]  step_chan;
    logic [15:0] a_offset;
    logic [15:0] byte_count;
  } regs_wr_t;

  function automatic logic [2:0] lowest_bit(input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

  // b-bus pattern offset for a transfer mode and unit
  function automatic logic [1:0] pat_off(input logic [2:0] p, input logic [1:0] u);
    logic [1:0] r;
    case (p)
      3'd1:        r = {1'b0, u[0]};
      3'd3, 3'd7:  r = {1'b0, u[1]};
      3'd4:        r = u;
      3'd5:        r = {1'b0, u[0]};
      default:     r = 2'd0;
    endcase
    return r;
  endfunction

  // pattern length minus one
  function automatic logic [1:0] pat_mask(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0:                    r = 2'd0;
      3'd1, 3'd2, 3'd6:        r = 2'd1;
      default:                 r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic system_bank(input logic [7:0] bank);
    return !bank[6];
  endfunction

  function automatic logic is_excluded(input logic [7:0] bank, input logic [15:0] off);
    logic hit;
    hit = (off >= 16'h2100 && off <= 16'h21FF) || (off >= 16'h4000 && off <= 16'h421F) ||
          (off >= 16'h4300 && off <= 16'h437F);
    return system_bank(bank) && hit;
  endfunction

  function automatic logic is_work_ram(input logic [7:0] bank, input logic [15:0] off);
    return (bank == 8'h7E) || (bank == 8'h7F) || (system_bank(bank) && off <= 16'h1FFF);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpdma_regfile.sv =====
// ----------------------------------------------------------------------------
// gpdma_regfile
// per-channel register sets with one read port and one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpdma_regfile #(
  parameter int CHANNELS = gpdma_pkg::CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [2:0]           rd_chan,
  input  wire gpdma_pkg::regs_wr_t  wr,
  output gpdma_pkg::chan_regs_t     rd_regs
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  gpdma_pkg::chan_regs_t regs [CHANNELS];

  logic [CH_W-1:0] wr_idx;
  logic [CH_W-1:0] step_idx;
  logic [CH_W-1:0] rd_idx;

  assign wr_idx   = wr.reg_chan[CH_W-1:0];
  assign step_idx = wr.step_chan[CH_W-1:0];
  assign rd_idx   = rd_chan[CH_W-1:0];
  assign rd_regs  = regs[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        regs[i] <= '0;
      end
    end else if (wr.reg_en) begin
      case (wr.reg_idx)
        gpdma_pkg::REG_CTRL:     regs[wr_idx].channel_control    <= wr.reg_data;
        gpdma_pkg::REG_BBASE:    regs[wr_idx].b_base             <= wr.reg_data;
        gpdma_pkg::REG_AOFF_LO:  regs[wr_idx].a_offset[7:0]      <= wr.reg_data;
        gpdma_pkg::REG_AOFF_HI:  regs[wr_idx].a_offset[15:8]     <= wr.reg_data;
        gpdma_pkg::REG_ABANK:    regs[wr_idx].a_bank             <= wr.reg_data;
        gpdma_pkg::REG_COUNT_LO: regs[wr_idx].byte_count[7:0]    <= wr.reg_data;
        gpdma_pkg::REG_COUNT_HI: regs[wr_idx].byte_count[15:8]   <= wr.reg_data;
        gpdma_pkg::REG_IND_BANK: regs[wr_idx].indirect_bank      <= wr.reg_data;
        gpdma_pkg::REG_TABLE_LO: regs[wr_idx].table_address[7:0] <= wr.reg_data;
        gpdma_pkg::REG_TABLE_HI: regs[wr_idx].table_address[15:8] <= wr.reg_data;
        gpdma_pkg::REG_LINE:     regs[wr_idx].line_counter       <= wr.reg_data;
        gpdma_pkg::REG_SPARE,
        gpdma_pkg::REG_SPARE_ALT: regs[wr_idx].spare_byte        <= wr.reg_data;
        default: ;
      endcase
    end else if (wr.step_en) begin
      regs[step_idx].a_offset   <= wr.a_offset;
      regs[step_idx].byte_count <= wr.byte_count;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpdma_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpdma_ctrl
// transfer sequencing flags and the per-word result logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpdma_ctrl #(
  parameter int CHANNELS = gpdma_pkg::CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire gpdma_pkg::in_item_t   item,
  input  wire gpdma_pkg::chan_regs_t regs,
  output logic [2:0]                 rd_chan,
  output gpdma_pkg::regs_wr_t        wr,
  output gpdma_pkg::out_item_t       result
);

  localparam logic [7:0] CHAN_MASK = 8'((9'd1 << CHANNELS) - 9'd1);

  logic [7:0] enable_mask, enable_mask_next;
  logic       running, running_next;
  logic       opened, opened_next;
  logic       channel_opened, channel_opened_next;
  logic [1:0] unit_index, unit_index_next;

  logic [2:0]  cur;
  logic        chan_ok;
  logic [7:0]  rd_byte;
  logic [2:0]  pmode;
  logic [1:0]  step;
  logic [7:0]  b_reg;
  logic [15:0] off_next;
  logic [15:0] count_next;
  logic [7:0]  mask_drop;

  assign cur     = gpdma_pkg::lowest_bit(enable_mask);
  assign chan_ok = {1'b0, item.reg_channel} < 4'(CHANNELS);
  assign rd_chan = (item.command == gpdma_pkg::CMD_TICK) ? cur : item.reg_channel;

  assign pmode      = regs.channel_control[2:0];
  assign step       = regs.channel_control[4:3];
  assign b_reg      = regs.b_base + {6'd0, gpdma_pkg::pat_off(pmode, unit_index)};
  assign count_next = regs.byte_count - 16'd1;
  assign mask_drop  = enable_mask & ~(8'd1 << cur);

  always_comb begin
    case (step)
      gpdma_pkg::STEP_INC: off_next = regs.a_offset + 16'd1;
      gpdma_pkg::STEP_DEC: off_next = regs.a_offset - 16'd1;
      default:             off_next = regs.a_offset;
    endcase
  end

  always_comb begin
    case (item.reg_index)
      gpdma_pkg::REG_CTRL:      rd_byte = regs.channel_control;
      gpdma_pkg::REG_BBASE:     rd_byte = regs.b_base;
      gpdma_pkg::REG_AOFF_LO:   rd_byte = regs.a_offset[7:0];
      gpdma_pkg::REG_AOFF_HI:   rd_byte = regs.a_offset[15:8];
      gpdma_pkg::REG_ABANK:     rd_byte = regs.a_bank;
      gpdma_pkg::REG_COUNT_LO:  rd_byte = regs.byte_count[7:0];
      gpdma_pkg::REG_COUNT_HI:  rd_byte = regs.byte_count[15:8];
      gpdma_pkg::REG_IND_BANK:  rd_byte = regs.indirect_bank;
      gpdma_pkg::REG_TABLE_LO:  rd_byte = regs.table_address[7:0];
      gpdma_pkg::REG_TABLE_HI:  rd_byte = regs.table_address[15:8];
      gpdma_pkg::REG_LINE:      rd_byte = regs.line_counter;
      gpdma_pkg::REG_SPARE,
      gpdma_pkg::REG_SPARE_ALT: rd_byte = regs.spare_byte;
      default:                  rd_byte = item.open_bus;
    endcase
    if (!chan_ok) rd_byte = item.open_bus;
  end

  always_comb begin
    enable_mask_next    = enable_mask;
    running_next        = running;
    opened_next         = opened;
    channel_opened_next = channel_opened;
    unit_index_next     = unit_index;
    result              = '0;
    wr                  = '0;
    wr.reg_chan         = item.reg_channel;
    wr.reg_idx          = item.reg_index;
    wr.reg_data         = item.write_data;
    wr.step_chan        = cur;
    wr.a_offset         = off_next;
    wr.byte_count       = count_next;

    case (item.command)
      gpdma_pkg::CMD_WRITE: begin
        wr.reg_en = advance && chan_ok;
      end
      gpdma_pkg::CMD_READ: begin
        result.read_data = rd_byte;
      end
      gpdma_pkg::CMD_START: begin
        enable_mask_next = item.write_data & CHAN_MASK;
        if (enable_mask_next == 8'd0) begin
          running_next = 1'b0;
        end else if (!running) begin
          running_next        = 1'b1;
          opened_next         = 1'b0;
          channel_opened_next = 1'b0;
          unit_index_next     = 2'd0;
        end
      end
      gpdma_pkg::CMD_PREEMPT: begin
        if (running && enable_mask != 8'd0 && item.write_data[cur]) begin
          enable_mask_next    = mask_drop;
          channel_opened_next = 1'b0;
          if (mask_drop == 8'd0) begin
            running_next         = 1'b0;
            result.transfer_done = 1'b1;
          end
        end
      end
      gpdma_pkg::CMD_TICK: begin
        if (running) begin
          if (!opened) begin
            // alignment to the next master cycle boundary
            opened_next       = 1'b1;
            result.cycle_cost = gpdma_pkg::ALIGN_BASE - {2'd0, item.pause_phase};
          end else if (enable_mask == 8'd0) begin
            running_next = 1'b0;
          end else begin
            result.active_channel = cur;
            result.cycle_cost     = gpdma_pkg::TICK_COST;
            if (!channel_opened) begin
              channel_opened_next = 1'b1;
              unit_index_next     = 2'd0;
            end else begin
              result.byte_valid   = 1'b1;
              result.a_address    = {regs.a_bank, regs.a_offset};
              result.b_register   = b_reg;
              result.to_a_bus     = regs.channel_control[7];
              result.a_excluded   = gpdma_pkg::is_excluded(regs.a_bank, regs.a_offset);
              result.port_refused = gpdma_pkg::is_work_ram(regs.a_bank, regs.a_offset) &&
                                    (b_reg[7:2] == 6'b100000);
              unit_index_next     = (unit_index + 2'd1) & gpdma_pkg::pat_mask(pmode);
              wr.step_en          = advance;
              if (count_next == 16'd0) begin
                enable_mask_next    = mask_drop;
                channel_opened_next = 1'b0;
                if (mask_drop == 8'd0) begin
                  running_next         = 1'b0;
                  result.transfer_done = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    result.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= '0;
      running        <= 1'b0;
      opened         <= 1'b0;
      channel_opened <= 1'b0;
      unit_index     <= '0;
    end else if (advance) begin
      enable_mask    <= enable_mask_next;
      running        <= running_next;
      opened         <= opened_next;
      channel_opened <= channel_opened_next;
      unit_index     <= unit_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/general_purpose_dma_channel_engine_unit.sv =====
// flow: a request word is held in the input register, worked on there and the
//   result word is registered in the result register when the held word retires
// throughput: one word per clock; the only stall is a full result register
// reset: synchronous, clears all channel registers, the enable mask and the flags
// ----------------------------------------------------------------------------
// general_purpose_dma_channel_engine_unit
// eight-channel byte dma sequencer with register access, start, preempt and tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module general_purpose_dma_channel_engine_unit #(
  parameter int CHANNELS = gpdma_pkg::CHANNELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire gpdma_pkg::in_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output gpdma_pkg::out_item_t     rsp
);

  // input register: holds the word being worked on
  logic                 s_valid;
  gpdma_pkg::in_item_t  s_item;

  // result register
  logic                 o_valid;
  gpdma_pkg::out_item_t o_item;

  // the held word is retired when the result register is free or emptying
  logic advance;

  gpdma_pkg::chan_regs_t chan_regs;
  gpdma_pkg::regs_wr_t   regs_wr;
  gpdma_pkg::out_item_t  result;
  logic [2:0]            rd_chan;

  assign advance   = s_valid && (!o_valid || rsp_ready);
  assign req_ready = !s_valid || advance;
  assign rsp_valid = o_valid;
  assign rsp       = o_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_item <= result;
    end
  end

  // per-channel register sets, read at the served or addressed channel
  gpdma_regfile #(
    .CHANNELS(CHANNELS)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_chan (rd_chan),
    .wr      (regs_wr),
    .rd_regs (chan_regs)
  );

  // sequencing flags and result build, state moves only when a word retires
  gpdma_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s_item),
    .regs    (chan_regs),
    .rd_chan (rd_chan),
    .wr      (regs_wr),
    .result  (result)
  );

  // a retired word always shows up in the result register
  `GPD_ASSERT(a_retire_shows, clk, rst, advance |=> o_valid, "retired word lost")
  // a held word that cannot retire stays put
  `GPD_ASSERT(a_hold_input, clk, rst, (s_valid && !advance) |=> (s_valid && $stable(s_item)), "held word changed")
  // a byte move always costs one channel tick
  `GPD_ASSERT(a_byte_cost, clk, rst, (o_valid && o_item.byte_valid) |-> (o_item.cycle_cost == gpdma_pkg::TICK_COST), "byte move cost wrong")
  // the end of a transfer leaves the engine idle
  `GPD_NEVER(a_done_idle, clk, rst, o_valid && o_item.transfer_done && o_item.busy_res, "done while busy")

endmodule

`default_nettype wire

// ===== tb/gpdma_engine_mirror.sv =====
// ----------------------------------------------------------------------------
// gpdma_engine_mirror
// watches both channels of the dma engine, keeps its own copy of the channel
// registers and transfer flags, works out the result word of every accepted
// request word and compares it with the result words in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpdma_engine_mirror (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  gpdma_pkg::in_item_t   req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  gpdma_pkg::out_item_t  rsp,
  output int                    mismatch_count,
  output int                    outcome_backlog
);

  import gpdma_pkg::*;

  chan_regs_t chan [8];
  logic [7:0] sel_mask;
  logic       running;
  logic       aligned;
  logic       chan_open;
  logic [1:0] unit_idx;
  out_item_t  outcome_q [$];

  initial mismatch_count = 0;
  initial outcome_backlog = 0;

  // b-bus offsets of the four units of each transfer pattern, unit 0 in the low bits
  function automatic logic [1:0] unit_offset(input logic [2:0] pattern, input logic [1:0] u);
    logic [7:0] row;
    case (pattern)
      3'd1:       row = 8'h04;
      3'd3, 3'd7: row = 8'h50;
      3'd4:       row = 8'hE4;
      3'd5:       row = 8'h44;
      default:    row = 8'h00;
    endcase
    return row[u * 2 +: 2];
  endfunction

  function automatic int unit_count(input logic [2:0] pattern);
    case (pattern)
      3'd0:             return 1;
      3'd1, 3'd2, 3'd6: return 2;
      default:          return 4;
    endcase
  endfunction

  function automatic logic in_system_bank(input logic [7:0] bank);
    return (bank <= 8'h3F) || (bank >= 8'h80 && bank <= 8'hBF);
  endfunction

  function automatic logic in_register_range(input logic [7:0] bank, input logic [15:0] off);
    logic hit;
    hit = (off >= 16'h2100 && off <= 16'h21FF) || (off >= 16'h4000 && off <= 16'h41FF) ||
          (off >= 16'h4200 && off <= 16'h421F) || (off >= 16'h4300 && off <= 16'h437F);
    return in_system_bank(bank) && hit;
  endfunction

  function automatic logic in_work_ram(input logic [7:0] bank, input logic [15:0] off);
    if (bank == 8'h7E || bank == 8'h7F) return 1'b1;
    return in_system_bank(bank) && off <= 16'h1FFF;
  endfunction

  function automatic logic [2:0] first_channel(input logic [7:0] m);
    for (int i = 0; i < 8; i++) begin
      if (m[i]) return 3'(i);
    end
    return 3'd0;
  endfunction

  function automatic logic [7:0] reg_value(input chan_regs_t r, input logic [3:0] idx,
                                           input logic [7:0] bus);
    case (idx)
      REG_CTRL:                 return r.channel_control;
      REG_BBASE:                return r.b_base;
      REG_AOFF_LO:              return r.a_offset[7:0];
      REG_AOFF_HI:              return r.a_offset[15:8];
      REG_ABANK:                return r.a_bank;
      REG_COUNT_LO:             return r.byte_count[7:0];
      REG_COUNT_HI:             return r.byte_count[15:8];
      REG_IND_BANK:             return r.indirect_bank;
      REG_TABLE_LO:             return r.table_address[7:0];
      REG_TABLE_HI:             return r.table_address[15:8];
      REG_LINE:                 return r.line_counter;
      REG_SPARE, REG_SPARE_ALT: return r.spare_byte;
      default:                  return bus;
    endcase
  endfunction

  task automatic store_reg(input logic [2:0] c, input logic [3:0] idx, input logic [7:0] v);
    case (idx)
      REG_CTRL:                 chan[c].channel_control = v;
      REG_BBASE:                chan[c].b_base = v;
      REG_AOFF_LO:              chan[c].a_offset[7:0] = v;
      REG_AOFF_HI:              chan[c].a_offset[15:8] = v;
      REG_ABANK:                chan[c].a_bank = v;
      REG_COUNT_LO:             chan[c].byte_count[7:0] = v;
      REG_COUNT_HI:             chan[c].byte_count[15:8] = v;
      REG_IND_BANK:             chan[c].indirect_bank = v;
      REG_TABLE_LO:             chan[c].table_address[7:0] = v;
      REG_TABLE_HI:             chan[c].table_address[15:8] = v;
      REG_LINE:                 chan[c].line_counter = v;
      REG_SPARE, REG_SPARE_ALT: chan[c].spare_byte = v;
      default: ;
    endcase
  endtask

  // takes a channel out of the selection; the transfer ends with the last one
  task automatic deselect(input logic [2:0] c, output logic last);
    sel_mask[c] = 1'b0;
    chan_open = 1'b0;
    last = (sel_mask == 8'h00);
    if (last) running = 1'b0;
  endtask

  task automatic advance_engine(input in_item_t w, output out_item_t o);
    logic [2:0] c;
    logic [7:0] ctl;
    logic [7:0] b;
    logic [7:0] bank;
    logic [15:0] off;
    logic last;
    o = '0;
    case (w.command)
      CMD_WRITE: store_reg(w.reg_channel, w.reg_index, w.write_data);
      CMD_READ:  o.read_data = reg_value(chan[w.reg_channel], w.reg_index, w.open_bus);
      CMD_START: begin
        sel_mask = w.write_data;
        if (sel_mask == 8'h00) begin
          running = 1'b0;
        end else if (!running) begin
          running = 1'b1;
          aligned = 1'b0;
          chan_open = 1'b0;
          unit_idx = 2'd0;
        end
      end
      CMD_PREEMPT: begin
        if (running && sel_mask != 8'h00) begin
          c = first_channel(sel_mask);
          if (w.write_data[c]) begin
            deselect(c, last);
            o.transfer_done = last;
          end
        end
      end
      CMD_TICK: begin
        if (running) begin
          if (!aligned) begin
            aligned = 1'b1;
            o.cycle_cost = ALIGN_BASE - 5'(w.pause_phase);
          end else if (sel_mask == 8'h00) begin
            running = 1'b0;
          end else begin
            c = first_channel(sel_mask);
            o.active_channel = c;
            o.cycle_cost = TICK_COST;
            if (!chan_open) begin
              chan_open = 1'b1;
              unit_idx = 2'd0;
            end else begin
              ctl = chan[c].channel_control;
              bank = chan[c].a_bank;
              off = chan[c].a_offset;
              b = chan[c].b_base + 8'(unit_offset(ctl[2:0], unit_idx));
              o.byte_valid = 1'b1;
              o.a_address = {bank, off};
              o.b_register = b;
              o.to_a_bus = ctl[7];
              o.a_excluded = in_register_range(bank, off);
              o.port_refused = in_work_ram(bank, off) && b >= 8'h80 && b <= 8'h83;
              if (ctl[4:3] == STEP_INC) chan[c].a_offset = off + 16'd1;
              else if (ctl[4:3] == STEP_DEC) chan[c].a_offset = off - 16'd1;
              unit_idx = 2'((int'(unit_idx) + 1) % unit_count(ctl[2:0]));
              chan[c].byte_count = chan[c].byte_count - 16'd1;
              if (chan[c].byte_count == 16'd0) begin
                deselect(c, last);
                o.transfer_done = last;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.busy_res = running;
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) chan[i] = '0;
      sel_mask = 8'h00;
      running = 1'b0;
      aligned = 1'b0;
      chan_open = 1'b0;
      unit_idx = 2'd0;
      outcome_q.delete();
    end else begin
      // result side first: a word accepted on this edge cannot answer this edge's request
      if (rsp_valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with nothing outstanding, actual 0x%0h", $time, rsp);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("read_data", want.read_data, rsp.read_data);
          compare_field("byte_valid", want.byte_valid, rsp.byte_valid);
          compare_field("a_address", want.a_address, rsp.a_address);
          compare_field("b_register", want.b_register, rsp.b_register);
          compare_field("to_a_bus", want.to_a_bus, rsp.to_a_bus);
          compare_field("active_channel", want.active_channel, rsp.active_channel);
          compare_field("a_excluded", want.a_excluded, rsp.a_excluded);
          compare_field("port_refused", want.port_refused, rsp.port_refused);
          compare_field("cycle_cost", want.cycle_cost, rsp.cycle_cost);
          compare_field("transfer_done", want.transfer_done, rsp.transfer_done);
          compare_field("busy_res", want.busy_res, rsp.busy_res);
        end
      end
      if (req_valid && req_ready) begin
        advance_engine(req, want);
        outcome_q.push_back(want);
      end
    end
    outcome_backlog <= outcome_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the eight-channel dma engine: a short directed run
// through register access, start, preempt, ticks and the corner cases, then
// randomly programmed transfers with noise words mixed in, random stalls on
// both channels and a calm tail; checking is done by the mirror beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import gpdma_pkg::*;

  // cycles with no word moving on either channel before the run is called hung
  localparam int STUCK_LIMIT = 2000;
  localparam int WORD_TARGET = 750;
  // the last stretch of the run goes without any idling
  localparam int CALM_FROM   = 660;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_item_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp;

  int mismatch_count;
  int outcome_backlog;
  int words_sent = 0;
  int stuck_cycles = 0;
  int stall_left = 0;
  int idle_odds = 1;
  logic calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  general_purpose_dma_channel_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  gpdma_engine_mirror mirror (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .mismatch_count  (mismatch_count),
    .outcome_backlog (outcome_backlog)
  );

  // result side back-pressure: ready drops for random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      rsp_ready <= (stall_left == 0);
    end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // hang detection: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("general_purpose_dma_channel_engine_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // presents one request word and holds it until the block takes it; pause phase
  // and open bus are free-running noise on every word
  task automatic issue(input logic [2:0] cmd, input logic [2:0] ch, input logic [3:0] idx,
                       input logic [7:0] data);
    in_item_t w;
    w.command = cmd;
    w.reg_channel = ch;
    w.reg_index = idx;
    w.write_data = data;
    w.pause_phase = 3'($urandom);
    w.open_bus = 8'($urandom);
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds * 2) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    words_sent++;
  endtask

  // one transfer: program the selected channels, start, tick it through with
  // occasional noise words, and sometimes stop it with an empty start mask
  task automatic run_transfer();
    logic [7:0]  mask;
    logic [7:0]  bank;
    logic [7:0]  bbase;
    logic [15:0] aoff;
    logic [15:0] count;
    int          ticks;
    bit          endless;
    idle_odds = $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) mask = 8'($urandom_range(1, 255));
    else mask = 8'(1 << $urandom_range(0, 7)) | 8'(1 << $urandom_range(0, 7));
    ticks = 1;
    endless = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (mask[c]) begin
        // mostly short counts; now and then a long one or zero (a full 64k)
        if ($urandom_range(0, 15) == 0) count = 16'($urandom);
        else count = 16'($urandom_range(1, 6));
        if (count == 16'd0 || count > 16'd40) endless = 1'b1;
        ticks += int'(count) + 1;
        // banks around the system, work ram and plain ranges
        case ($urandom_range(0, 9))
          0:       bank = 8'h00;
          1:       bank = 8'h3F;
          2:       bank = 8'h40;
          3:       bank = 8'h7E;
          4:       bank = 8'h7F;
          5:       bank = 8'h80;
          6:       bank = 8'hBF;
          7:       bank = 8'hC0;
          default: bank = 8'($urandom);
        endcase
        // offsets near the edges of the register and work ram windows
        case ($urandom_range(0, 14))
          0:       aoff = 16'h0000;
          1:       aoff = 16'h1FFF;
          2:       aoff = 16'h2100;
          3:       aoff = 16'h21FF;
          4:       aoff = 16'h4000;
          5:       aoff = 16'h41FF;
          6:       aoff = 16'h4200;
          7:       aoff = 16'h421F;
          8:       aoff = 16'h4300;
          9:       aoff = 16'h437F;
          10:      aoff = 16'hFFFF;
          default: aoff = 16'($urandom);
        endcase
        aoff = aoff + 16'($urandom_range(0, 4)) - 16'd2;
        // b offsets around the work ram port window and the wrap at 0xff
        case ($urandom_range(0, 3))
          0, 1:    bbase = 8'h7D + 8'($urandom_range(0, 6));
          2:       bbase = 8'hFF - 8'($urandom_range(0, 2));
          default: bbase = 8'($urandom);
        endcase
        issue(CMD_WRITE, 3'(c), REG_CTRL, 8'($urandom));
        issue(CMD_WRITE, 3'(c), REG_BBASE, bbase);
        issue(CMD_WRITE, 3'(c), REG_AOFF_LO, aoff[7:0]);
        issue(CMD_WRITE, 3'(c), REG_AOFF_HI, aoff[15:8]);
        issue(CMD_WRITE, 3'(c), REG_ABANK, bank);
        issue(CMD_WRITE, 3'(c), REG_COUNT_LO, count[7:0]);
        issue(CMD_WRITE, 3'(c), REG_COUNT_HI, count[15:8]);
      end
    end
    if (endless) ticks = $urandom_range(4, 30);
    else ticks += $urandom_range(0, 3);
    issue(CMD_START, 3'($urandom), 4'($urandom), mask);
    repeat (ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 5))
          0: issue(CMD_PREEMPT, 3'($urandom), 4'($urandom), 8'($urandom));
          // registers that the engine does not use, plus the open bus holes
          1: issue(CMD_WRITE, 3'($urandom), 4'($urandom_range(REG_IND_BANK, REG_SPARE_ALT)),
                   8'($urandom));
          // reserved codes above the tick
          2: issue(CMD_TICK + 3'($urandom_range(1, 3)), 3'($urandom), 4'($urandom),
                   8'($urandom));
          3: begin
            // reselect while running; may pull in channels nobody programmed
            issue(CMD_START, 3'($urandom), 4'($urandom), 8'($urandom));
            endless = 1'b1;
          end
          default: issue(CMD_READ, 3'($urandom), 4'($urandom), 8'($urandom));
        endcase
      end
      issue(CMD_TICK, 3'($urandom), 4'($urandom), 8'($urandom));
    end
    if (endless || $urandom_range(0, 1) == 0)
      issue(CMD_START, 3'($urandom), 4'($urandom), 8'h00);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // tick with nothing running, then a reserved command
    issue(CMD_TICK, 3'd0, REG_CTRL, 8'h00);
    issue(CMD_TICK + 3'd3, 3'd7, REG_SPARE_ALT, 8'hFF);

    // channel 7: b to a, decrementing across the 16-bit wrap, four-unit pattern
    // starting at b 0x80 in low work ram, so the port refusal shows
    issue(CMD_WRITE, 3'd7, REG_CTRL, {1'b1, 2'b00, STEP_DEC, 3'd4});
    issue(CMD_WRITE, 3'd7, REG_BBASE, 8'h80);
    issue(CMD_WRITE, 3'd7, REG_AOFF_LO, 8'h01);
    issue(CMD_WRITE, 3'd7, REG_COUNT_LO, 8'h03);
    issue(CMD_READ, 3'd7, REG_CTRL, 8'h00);
    issue(CMD_READ, 3'd7, 4'd13, 8'h00);
    issue(CMD_WRITE, 3'd0, REG_SPARE_ALT, 8'hFF);
    issue(CMD_READ, 3'd0, REG_SPARE, 8'h00);

    // alignment, channel overhead, three bytes; the last one finishes the transfer
    issue(CMD_START, 3'd0, REG_CTRL, 8'h80);
    repeat (5) issue(CMD_TICK, 3'd0, REG_CTRL, 8'h00);

    // channel 0 with a zero count runs for 64k bytes; preempt it after one byte
    issue(CMD_START, 3'd0, REG_CTRL, 8'h01);
    repeat (3) issue(CMD_TICK, 3'd0, REG_CTRL, 8'h00);
    issue(CMD_PREEMPT, 3'd0, REG_CTRL, 8'hFF);

    // empty start mask stops a running transfer without a done flag
    issue(CMD_START, 3'd0, REG_CTRL, 8'h01);
    issue(CMD_TICK, 3'd0, REG_CTRL, 8'h00);
    issue(CMD_START, 3'd0, REG_CTRL, 8'h00);
    issue(CMD_TICK, 3'd0, REG_CTRL, 8'h00);

    while (words_sent < WORD_TARGET) begin
      if (words_sent >= CALM_FROM) calm <= 1'b1;
      run_transfer();
    end

    // drain: wait for every outstanding result word, then a few quiet cycles
    req_valid <= 1'b0;
    do @(posedge clk); while (outcome_backlog != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("general_purpose_dma_channel_engine_unit verification clean");
    else
      $display("general_purpose_dma_channel_engine_unit verification failed");
    $finish;
  end

endmodule
